[src/line_follow_pid_drive_defines.svh]
`ifndef LINE_FOLLOW_PID_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_DRIVE_DEFINES_SVH

// Assertion helpers. Each expects signals named clk and rst_n in the
// enclosing module, and is disabled while reset is held.

// The consequent must hold in the same cycle as the antecedent.
`define LFPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lfpd_pkg.sv]
package lfpd_pkg;

  // Sensor array.
  localparam int SENSOR_COUNT = 5;
  localparam int SENSOR_HALF  = SENSOR_COUNT / 2;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int COUNT_W      = $clog2(SENSOR_COUNT + 1);
  // The magnitude of the weight sum never exceeds SENSOR_COUNT squared.
  localparam int SUM_MAG_W    = $clog2(SENSOR_COUNT * SENSOR_COUNT + 1);
  localparam int SUM_W        = SUM_MAG_W + 1;

  // Fixed-point formats.
  localparam int ERR_W   = 16;  // Q3.12
  localparam int ERR_FRAC = 12;
  localparam int DT_W    = 20;  // Q4.16
  localparam int DT_FRAC = 16;
  localparam int INTEG_W = 40;  // Q27.12
  localparam int GAIN_W  = 8;
  localparam int DRIVE_W = 9;
  localparam int DRIVE_LIMIT = 255;
  localparam int PID_W   = 50;

  // Shared divider.
  localparam int QUO_W   = ERR_W + DT_FRAC;
  localparam int STEP_W  = $clog2(QUO_W + 1);
  localparam int ERR_DIV_STEPS = SUM_MAG_W + ERR_FRAC;
  localparam int DERIV_W = QUO_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BASE  = 3'd4;

  // Request to the shared divider. The dividend is aligned to the top of
  // the word so that steps iterations yield the whole quotient.
  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [DT_W-1:0]   divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

[src/lfpd_divider.sv]
module lfpd_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfpd_pkg::div_req_t         div_req,
  output logic [lfpd_pkg::QUO_W-1:0] div_quo,
  output logic                       div_done
);
  import lfpd_pkg::*;

  logic [QUO_W-1:0]  quo_r;
  logic [DT_W-1:0]   rem_r;
  logic [DT_W-1:0]   divisor_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DT_W:0]     trial;
  logic              fits;
  logic [DT_W:0]     rem_nxt;

  // One restoring step: bring down the next dividend bit and subtract
  // the divisor where it fits.
  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    fits    = (trial >= {1'b0, divisor_r});
    rem_nxt = fits ? (trial - {1'b0, divisor_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        quo_r     <= div_req.dividend;
        rem_r     <= '0;
        divisor_r <= div_req.divisor;
        cnt_r     <= div_req.steps;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[QUO_W-2:0], fits};
        rem_r <= rem_nxt[DT_W-1:0];
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_quo  = quo_r;
  assign div_done = done_r;

endmodule

[src/line_follow_pid_drive.sv]
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// in_      | into      | in_valid/in_stall  | in_sensor_bits, in_time_step
// out_     | out of    | out_valid/out_stall| out_drive_a, out_drive_b (signed)
// cfg_     | into      | cfg_wr_en          | cfg_index, cfg_data
//
// A request keeps the input stalled from acceptance until its result is registered;
// the bit-serial divider spends 17 steps of it on the line error (skipped when no
// sensor sees the line) and 32 on the derivative.
// A zero time step is accepted and retired, and the block is ready in the next cycle.
// Reset (rst_n low, synchronous) clears the gains, bases, held error and integral.
// While a result is stalled the next request waits in its last step, and no new one is taken.
`include "line_follow_pid_drive_defines.svh"

module line_follow_pid_drive (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration write port.
  input  logic                                    cfg_wr_en,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]         cfg_data,
  // Sensor request channel.
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [lfpd_pkg::SENSOR_COUNT-1:0]       in_sensor_bits,
  input  logic [lfpd_pkg::DT_W-1:0]               in_time_step,
  // Drive result channel.
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]     out_drive_a,
  output logic signed [lfpd_pkg::DRIVE_W-1:0]     out_drive_b
);
  import lfpd_pkg::*;

  localparam int MUL_A_W = INTEG_W;
  localparam int MUL_P_W = MUL_A_W + DT_W + 1;
  localparam logic [PID_W-1:0] DT_ROUND = PID_W'((1 << DT_FRAC) - 1);
  localparam logic signed [PID_W-1:0] DRIVE_LIM_Q =
    PID_W'(DRIVE_LIMIT * (1 << ERR_FRAC));
  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  // The one drive code that the clamp must never let through.
  localparam logic [DRIVE_W-1:0] DRIVE_FORBIDDEN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // The sequencer walks the sensors, then reuses the divider and the
  // multiplier for each term of the controller in turn.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ERR_START,
    ST_ERR_DIV,
    ST_MUL_INC,
    ST_INTEG,
    ST_DER_START,
    ST_DER_DIV,
    ST_MUL_K,
    ST_MUL_D,
    ST_ACC_D,
    ST_DRIVE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] integ_gain_r;
  logic [GAIN_W-1:0] deriv_gain_r;
  logic [GAIN_W-1:0] left_base_r;
  logic [GAIN_W-1:0] right_base_r;

  // Controller state kept across requests.
  logic signed [ERR_W-1:0]   line_error_r;
  logic signed [INTEG_W-1:0] integral_r;

  // Working registers of one request.
  logic [SENSOR_COUNT-1:0]   bits_r;
  logic [DT_W-1:0]           dt_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [COUNT_W-1:0]        count_r;
  logic signed [ERR_W-1:0]   err_new_r;
  logic signed [DERIV_W-1:0] deriv_r;
  logic signed [PID_W-1:0]   prod_r;
  logic signed [PID_W-1:0]   acc_r;

  // Result register.
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_a_r;
  logic signed [DRIVE_W-1:0] out_drive_b_r;

  // Shared divider.
  div_req_t         div_req;
  logic [QUO_W-1:0] div_quo;
  logic             div_done;

  // Combinational helpers.
  logic                       in_take;
  logic signed [SUM_W-1:0]    weight;
  logic signed [SUM_W-1:0]    sum_abs;
  logic signed [ERR_W:0]      diff;
  logic signed [ERR_W:0]      diff_abs;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [DT_W-1:0]            mul_b;
  logic signed [MUL_P_W-1:0]  mul_full;
  logic signed [PID_W-1:0]    inc_adj;
  logic signed [PID_W-1:0]    incr;
  logic [INTEG_W:0]           int_sum;
  logic signed [PID_W-1:0]    sum_a;
  logic signed [PID_W-1:0]    sum_b;
  logic                       out_free;

  // Clamp a Q12 value to the drive range and drop the fraction, rounding
  // toward zero.
  function automatic logic signed [DRIVE_W-1:0] drive_of(
    input logic signed [PID_W-1:0] v
  );
    logic signed [PID_W-1:0] mag;
    logic [DRIVE_W-1:0]      q;
    if (v > DRIVE_LIM_Q) begin
      mag = DRIVE_LIM_Q;
    end else if (v < -DRIVE_LIM_Q) begin
      mag = DRIVE_LIM_Q;
    end else if (v < 0) begin
      mag = -v;
    end else begin
      mag = v;
    end
    q = mag[ERR_FRAC +: DRIVE_W];
    return (v < 0) ? -$signed(q) : $signed(q);
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The sensor weight of the bit under inspection runs from minus half the
  // array width up to plus half.
  assign weight = $signed({{(SUM_W-IDX_W){1'b0}}, idx_r}) - $signed(SUM_W'(SENSOR_HALF));
  assign sum_abs = sum_r[SUM_W-1] ? -sum_r : sum_r;

  // The new error minus the held one feeds the derivative. Both stay put
  // until the result leaves, so the sign is still valid when the divider
  // returns.
  assign diff     = $signed({err_new_r[ERR_W-1], err_new_r})
                  - $signed({line_error_r[ERR_W-1], line_error_r});
  assign diff_abs = diff[ERR_W] ? -diff : diff;

  // Divider requests: the mean of the weights, then the rate of change.
  always_comb begin
    div_req = '0;
    case (state_r)
      ST_ERR_START: begin
        div_req.start    = (count_r != '0);
        div_req.dividend = {sum_abs[SUM_MAG_W-1:0], {(QUO_W-SUM_MAG_W){1'b0}}};
        div_req.divisor  = {{(DT_W-COUNT_W){1'b0}}, count_r};
        div_req.steps    = STEP_W'(ERR_DIV_STEPS);
      end
      ST_DER_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {diff_abs[ERR_W-1:0], {DT_FRAC{1'b0}}};
        div_req.divisor  = dt_r;
        div_req.steps    = STEP_W'(QUO_W);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  lfpd_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_req  (div_req),
    .div_quo  (div_quo),
    .div_done (div_done)
  );

  // Multiplier operands. The product is registered and taken up by the
  // state that follows.
  always_comb begin
    case (state_r)
      ST_MUL_INC: begin
        mul_a = {{(MUL_A_W-ERR_W){err_new_r[ERR_W-1]}}, err_new_r};
        mul_b = dt_r;
      end
      ST_INTEG: begin
        mul_a = {{(MUL_A_W-ERR_W){err_new_r[ERR_W-1]}}, err_new_r};
        mul_b = {{(DT_W-GAIN_W){1'b0}}, prop_gain_r};
      end
      ST_MUL_K: begin
        mul_a = integral_r;
        mul_b = {{(DT_W-GAIN_W){1'b0}}, integ_gain_r};
      end
      ST_MUL_D: begin
        mul_a = {{(MUL_A_W-DERIV_W){deriv_r[DERIV_W-1]}}, deriv_r};
        mul_b = {{(DT_W-GAIN_W){1'b0}}, deriv_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // Integral step: error times time step, scaled back to Q12 with the
  // fraction dropped toward zero, then a saturating add.
  assign inc_adj = prod_r + (prod_r[PID_W-1] ? $signed(DT_ROUND) : $signed(PID_W'(0)));
  assign incr    = inc_adj >>> DT_FRAC;
  assign int_sum = {integral_r[INTEG_W-1], integral_r} + incr[INTEG_W:0];

  // Channel A takes the right base plus the correction, channel B the left
  // base minus it.
  assign sum_a = $signed({{(PID_W-GAIN_W-ERR_FRAC){1'b0}}, right_base_r, {ERR_FRAC{1'b0}}})
               + acc_r;
  assign sum_b = $signed({{(PID_W-GAIN_W-ERR_FRAC){1'b0}}, left_base_r, {ERR_FRAC{1'b0}}})
               - acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      left_base_r  <= '0;
      right_base_r <= '0;
      line_error_r <= '0;
      integral_r   <= '0;
      idx_r        <= '0;
      count_r      <= '0;
      sum_r        <= '0;
    end else begin
      // Configuration writes; unknown indexes are dropped.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PROP_GAIN:  prop_gain_r  <= cfg_data;
          CFG_INTEG_GAIN: integ_gain_r <= cfg_data;
          CFG_DERIV_GAIN: deriv_gain_r <= cfg_data;
          CFG_LEFT_BASE:  left_base_r  <= cfg_data;
          CFG_RIGHT_BASE: right_base_r <= cfg_data;
          default: begin
          end
        endcase
      end

      // The drive step refills the output register itself, so the result
      // is only dropped here in the other states.
      if (out_valid_r && !out_stall && (state_r != ST_DRIVE)) begin
        out_valid_r <= 1'b0;
      end

      prod_r <= mul_full[PID_W-1:0];

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            bits_r  <= in_sensor_bits;
            dt_r    <= in_time_step;
            idx_r   <= '0;
            sum_r   <= '0;
            count_r <= '0;
            // A zero time step yields nothing and leaves the state alone.
            state_r <= (in_time_step != '0) ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (bits_r[idx_r]) begin
            sum_r   <= sum_r + weight;
            count_r <= count_r + COUNT_W'(1);
          end
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(SENSOR_COUNT - 1)) begin
            state_r <= ST_ERR_START;
          end
        end
        ST_ERR_START: begin
          // With no sensor on the line the previous error carries over.
          if (count_r == '0) begin
            err_new_r <= line_error_r;
            state_r   <= ST_MUL_INC;
          end else begin
            state_r   <= ST_ERR_DIV;
          end
        end
        ST_ERR_DIV: begin
          if (div_done) begin
            err_new_r <= sum_r[SUM_W-1] ? -div_quo[ERR_W-1:0] : div_quo[ERR_W-1:0];
            state_r   <= ST_MUL_INC;
          end
        end
        ST_MUL_INC: begin
          state_r <= ST_INTEG;
        end
        ST_INTEG: begin
          if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
            integral_r <= int_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
          end else begin
            integral_r <= int_sum[INTEG_W-1:0];
          end
          state_r <= ST_DER_START;
        end
        ST_DER_START: begin
          // The proportional product arrives here and opens the sum.
          acc_r   <= prod_r;
          state_r <= ST_DER_DIV;
        end
        ST_DER_DIV: begin
          if (div_done) begin
            deriv_r <= diff[ERR_W] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
            state_r <= ST_MUL_K;
          end
        end
        ST_MUL_K: begin
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_ACC_D;
        end
        ST_ACC_D: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_DRIVE;
        end
        ST_DRIVE: begin
          // Wait here until the output register can take the result.
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_drive_a_r <= drive_of(sum_a);
            out_drive_b_r <= drive_of(sum_b);
            line_error_r  <= err_new_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive_a = out_drive_a_r;
  assign out_drive_b = out_drive_b_r;

  `LFPD_ASSERT_NEXT(a_zero_dt_retires, in_take && (in_time_step == '0), !in_stall && $stable(line_error_r) && $stable(integral_r), "zero time step changed state or kept the block busy")
  `LFPD_ASSERT_SAME(a_div_done_in_div, div_done, (state_r == ST_ERR_DIV) || (state_r == ST_DER_DIV), "divider finished outside a divide step")
  `LFPD_ASSERT_NEXT(a_out_only_from_drive, !out_valid_r && (state_r != ST_DRIVE), !out_valid_r, "result appeared without a drive step")
  `LFPD_ASSERT_SAME(a_drive_in_range, out_valid_r, (out_drive_a_r != DRIVE_FORBIDDEN) && (out_drive_b_r != DRIVE_FORBIDDEN), "drive value escaped the clamp")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Testbench for the line-following PID drive block.
//
// The sensor request channel and the drive result channel are both driven
// with random gaps and stalls, and every accepted request is fed to a
// predictor that keeps its own copy of the held line error, the integral and
// the register file. Results are compared in order, field by field.
module testbench;
  import lfpd_pkg::*;

  // Fixed-point scale factors and bounds used by the predictor.
  localparam longint ERR_ONE   = longint'(1) << ERR_FRAC;
  localparam longint DT_ONE    = longint'(1) << DT_FRAC;
  localparam longint INTEG_TOP = (longint'(1) << (INTEG_W - 1)) - 1;
  localparam longint INTEG_BOT = -INTEG_TOP - 1;
  localparam longint DRIVE_TOP = longint'(DRIVE_LIMIT) * ERR_ONE;

  // A safe margin for a request to drain inside the block before a register
  // write or the final verdict.
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_GAP      = 11;
  localparam int PHASE_ITEMS  = 100;
  localparam int PHASES       = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive_a;
    logic signed [DRIVE_W-1:0] drive_b;
  } drive_pair_t;

  // The scoreboard owns the predicted drive values. It mirrors the block's
  // registers and state, and works out the drive pair for every request with
  // a nonzero time step as soon as the request is accepted.
  class drive_scoreboard;
    drive_pair_t             pending_drives[$];
    longint                  reg_val[5];
    logic signed [ERR_W-1:0] held_error;
    longint                  integral;
    int unsigned             failures;

    function new();
      foreach (reg_val[i]) reg_val[i] = 0;
      held_error = '0;
      integral   = 0;
      failures   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      // Writes to indexes beyond the last register are dropped.
      if (idx <= CFG_RIGHT_BASE) reg_val[idx] = val;
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    function logic signed [DRIVE_W-1:0] limit_drive(longint q12);
      if (q12 > DRIVE_TOP) q12 = DRIVE_TOP;
      if (q12 < -DRIVE_TOP) q12 = -DRIVE_TOP;
      return DRIVE_W'(q12 / ERR_ONE);
    endfunction

    function void note_request(logic [SENSOR_COUNT-1:0] bits, logic [DT_W-1:0] dt);
      longint      weight_sum, active, prev, err, step, incr, deriv, pid;
      drive_pair_t want;
      // A zero time step leaves everything untouched and yields nothing.
      if (dt == '0) return;
      step       = dt;
      weight_sum = 0;
      active     = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (bits[i]) begin
          weight_sum += i - SENSOR_HALF;
          active++;
        end
      end
      // With no sensor on the line the old error is kept.
      prev = held_error;
      if (active > 0) held_error = ERR_W'((weight_sum * ERR_ONE) / active);
      err = held_error;

      incr = (err * step) / DT_ONE;
      integral += incr;
      if (integral > INTEG_TOP) integral = INTEG_TOP;
      if (integral < INTEG_BOT) integral = INTEG_BOT;

      deriv = ((err - prev) * DT_ONE) / step;

      pid = reg_val[CFG_PROP_GAIN] * err
          + reg_val[CFG_INTEG_GAIN] * integral
          + reg_val[CFG_DERIV_GAIN] * deriv;

      want.drive_a = limit_drive(reg_val[CFG_RIGHT_BASE] * ERR_ONE + pid);
      want.drive_b = limit_drive(reg_val[CFG_LEFT_BASE] * ERR_ONE - pid);
      pending_drives.push_back(want);
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] a, logic signed [DRIVE_W-1:0] b);
      drive_pair_t want;
      if (pending_drives.size() == 0) begin
        failures++;
        $display("%0t: unexpected drive result a=%0d b=%0d", $time, a, b);
        return;
      end
      want = pending_drives.pop_front();
      if (a !== want.drive_a) begin
        failures++;
        $display("%0t: drive_a expected %0d, got %0d", $time, want.drive_a, a);
      end
      if (b !== want.drive_b) begin
        failures++;
        $display("%0t: drive_b expected %0d, got %0d", $time, want.drive_b, b);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [SENSOR_COUNT-1:0]     in_sensor_bits;
  logic [DT_W-1:0]             in_time_step;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [DRIVE_W-1:0]   out_drive_a;
  logic signed [DRIVE_W-1:0]   out_drive_b;

  drive_scoreboard sb;

  // Set by the stimulus to remove all idling on both sides, and to ask the
  // result side for one long hold-off.
  bit          no_gaps = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;

  line_follow_pid_drive u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sensor_bits (in_sensor_bits),
    .in_time_step   (in_time_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_a    (out_drive_a),
    .out_drive_b    (out_drive_b)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Sensor patterns lean a little towards the empty reading, so that the
  // held-error path is exercised often.
  function automatic logic [SENSOR_COUNT-1:0] pick_sensors();
    if ($urandom_range(0, 7) == 0) return '0;
    return SENSOR_COUNT'($urandom_range(0, (1 << SENSOR_COUNT) - 1));
  endfunction

  // Time steps mix zero, tiny, maximal, single-bit and fully random values.
  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DT_W'($urandom_range(1, 16));
      2:       return '1;
      3:       return DT_W'(1) << $urandom_range(0, DT_W - 1);
      default: return DT_W'($urandom_range(1, (1 << DT_W) - 1));
    endcase
  endfunction

  // Offers one request after a random gap and returns at the edge where it
  // is taken. The valid is left high, so back-to-back requests never see it
  // drop; the caller lowers it once a burst is over.
  task automatic send_request(input logic [SENSOR_COUNT-1:0] bits,
                              input logic [DT_W-1:0] dt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sensor_bits <= bits;
    in_time_step   <= dt;
    do @(posedge clk); while (in_stall);
    sb.note_request(bits, dt);
  endtask

  // Waits for every outstanding drive result, then gives the block time to
  // retire anything that produces no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write per edge; the enable stays high across the batch and
  // is dropped only at the end.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] prop, integ, deriv,
                               input logic [CFG_DATA_W-1:0] left_base, right_base);
    wait_idle();
    write_reg(CFG_PROP_GAIN, prop);
    write_reg(CFG_INTEG_GAIN, integ);
    write_reg(CFG_DERIV_GAIN, deriv);
    write_reg(CFG_LEFT_BASE, left_base);
    write_reg(CFG_RIGHT_BASE, right_base);
    // An index past the last register must leave the settings alone.
    write_reg(CFG_IDX_W'(CFG_RIGHT_BASE + 1 + $urandom_range(0, 2)),
              CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: stalls for a random number of cycles before each result,
  // and once on request for a long stretch while the sender keeps going.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_drive(out_drive_a, out_drive_b);
    end
  end

  // Request side and the overall sequence.
  initial begin
    logic [CFG_DATA_W-1:0] g_prop, g_integ, g_deriv, b_left, b_right;
    sb = new();
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_sensor_bits <= '0;
    in_time_step   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the registers at their reset values every drive must be zero.
    send_request(5'b00001, 20'h10000);
    send_request(5'b00000, 20'h00001);

    // Moderate gains, so that most of these results stay inside the limits.
    load_settings(8'd4, 8'd1, 8'd1, 8'd128, 8'd128);
    send_request(5'b00000, 20'h10000);   // nothing on the line, error held
    send_request(5'b00001, 20'h10000);   // far left sensor alone
    send_request(5'b00000, 20'h00001);   // held error with the shortest step
    send_request(5'b10000, 20'h00001);   // full swing over one tick
    send_request(5'b11111, 20'hFFFFF);   // all sensors, longest step
    send_request(5'b00011, 20'h00000);   // zero step: no result at all
    send_request(5'b11000, 20'h08000);
    send_request(5'b00111, 20'h04000);
    send_request(5'b01110, 20'h00100);
    send_request(5'b10001, 20'h10000);
    send_request(5'b00100, 20'hFFFFF);
    send_request(5'b01000, 20'h00000);
    send_request(5'b00010, 20'h00010);
    send_request(5'b10000, 20'hFFFFF);
    send_request(5'b00000, 20'hFFFFF);   // held far right error, long step

    // Every register at its top value: drives should pin to the limits.
    load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(5'b00001, 20'h00001);
    send_request(5'b10000, 20'hFFFFF);
    send_request(5'b00000, 20'h00000);
    send_request(5'b00100, 20'h00400);

    // Gains at the top with both bases at zero.
    load_settings(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_request(5'b11111, 20'h00002);
    send_request(5'b00011, 20'h80000);
    send_request(5'b11000, 20'h00001);
    send_request(5'b00000, 20'h00003);

    // Random phases, each with its own register settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          g_prop  = CFG_DATA_W'($urandom_range(0, 3));
          g_integ = CFG_DATA_W'($urandom_range(0, 1));
          g_deriv = CFG_DATA_W'($urandom_range(0, 2));
        end
        1: begin
          g_prop  = '1;
          g_integ = '1;
          g_deriv = '1;
        end
        2: begin
          g_prop  = CFG_DATA_W'($urandom);
          g_integ = CFG_DATA_W'($urandom);
          g_deriv = CFG_DATA_W'($urandom);
        end
        3: begin
          g_prop  = '0;
          g_integ = '0;
          g_deriv = '0;
        end
        default: begin
          g_prop  = CFG_DATA_W'($urandom_range(0, 8));
          g_integ = '0;
          g_deriv = CFG_DATA_W'($urandom_range(0, 4));
        end
      endcase
      if (phase == 1) begin
        b_left  = '1;
        b_right = '1;
      end else if (phase == 3) begin
        b_left  = '0;
        b_right = '0;
      end else begin
        b_left  = CFG_DATA_W'($urandom);
        b_right = CFG_DATA_W'($urandom);
      end
      load_settings(g_prop, g_integ, g_deriv, b_left, b_right);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // In the second phase the result side holds off for a long time
        // while requests keep coming with no gap, so the block backs up and
        // has to stall its input.
        if (phase == 1 && n == 0) begin
          no_gaps      = 1'b1;
          hold_off_req = 1'b1;
        end
        // The last phase opens with a stretch where neither side idles.
        if (phase == PHASES - 1 && n == 0) no_gaps = 1'b1;
        if (n == 40) no_gaps = 1'b0;
        if (phase == 1 && n < 40)
          send_request(pick_sensors(), DT_W'($urandom_range(1, (1 << DT_W) - 1)));
        else
          send_request(pick_sensors(), pick_step());
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[line_follow_pid_drive.f]
+incdir+src
src/lfpd_pkg.sv
src/lfpd_divider.sv
src/line_follow_pid_drive.sv
tb/sv/testbench.sv
